/* sv/piecewise_waveform_generator_defines.svh */
// Assertion macros for the piecewise waveform generator checker
`ifndef PIECEWISE_WAVEFORM_GENERATOR_DEFINES_SVH
`define PIECEWISE_WAVEFORM_GENERATOR_DEFINES_SVH
// Check a property outside reset
`define PWG_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("pwg assertion failed");
// Check a property at every edge, reset included
`define PWG_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("pwg assertion failed");
`endif

/* sv/pwg_pkg.sv */
// Shared constants and types of the piecewise waveform generator
`default_nettype none
package pwg_pkg;
  localparam int MAX_SEGMENTS = 64;
  localparam int SEG_IDX_W    = $clog2(MAX_SEGMENTS + 1);
  localparam int ENTRY_IDX_W  = $clog2(MAX_SEGMENTS);
  localparam int DATA_W       = 32;
  localparam int PROD_W       = 2 * DATA_W + 1;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_INTERPOLATE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_COUNT = 1'd1;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef struct packed {
    logic                    is_query;
    logic [ENTRY_IDX_W-1:0]  index;
    logic signed [DATA_W-1:0] value;
    logic [DATA_W-1:0]       duration;
    logic [DATA_W-1:0]       time_now;
  } op_t;

  typedef struct packed {
    logic                 interpolate;
    logic [SEG_IDX_W-1:0] count;
  } cfg_t;

  typedef struct packed {
    logic              start;
    logic [PROD_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quotient;
  } div_rsp_t;
endpackage
`default_nettype wire

/* sv/pwg_if.sv */
// Valid/ready channel interfaces for items and results
`default_nettype none
interface pwg_in_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [5:0]         entry_index;
  logic signed [31:0] entry_value;
  logic [31:0]        entry_duration;
  logic [31:0]        time_now;
  modport source (output valid, kind, entry_index, entry_value, entry_duration, time_now,
                  input ready);
  modport sink (input valid, kind, entry_index, entry_value, entry_duration, time_now,
                output ready);
endinterface

interface pwg_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] drive_value;
  logic [6:0]         segment_index;
  modport source (output valid, drive_value, segment_index, input ready);
  modport sink (input valid, drive_value, segment_index, output ready);
endinterface
`default_nettype wire

/* sv/piecewise_waveform_generator.sv */
// Piecewise waveform generator top level.
// A load writes the value table and then the start time; a query scans the start times,
// reads its segment, and when interpolating multiplies and then divides on the divider.
// The scan over start times reads one table entry per cycle from a one-read, one-write memory.
// Input and output are each buffered, so a two-item queue and the result register decouple
// the channels. Reset (synchronous, active high) clears the queue, registers and start times.
`default_nettype none
module piecewise_waveform_generator import pwg_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  pwg_in_if.sink                     items,
  pwg_out_if.source                  results
);
  logic                      interpolate;
  logic [SEG_IDX_W-1:0]      segment_count;
  cfg_t                      cfg;
  logic                      q_valid;
  op_t                       q_op;
  logic                      pop;
  div_req_t                  div_req;
  div_rsp_t                  div_rsp;
  logic                      res_valid;
  logic                      res_ready;
  logic signed [DATA_W-1:0]  res_value;
  logic [SEG_IDX_W-1:0]      res_index;
  logic                      out_valid;
  logic signed [DATA_W-1:0]  out_value;
  logic [SEG_IDX_W-1:0]      out_index;

  always_ff @(posedge clk) begin
    if (rst) begin
      interpolate   <= 1'b0;
      segment_count <= 7'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_INTERPOLATE:   interpolate   <= cfg_data[0];
        CFG_SEGMENT_COUNT: segment_count <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.interpolate = interpolate;
    if (segment_count == '0) cfg.count = 7'd1;
    else if (segment_count > 7'(MAX_SEGMENTS)) cfg.count = 7'(MAX_SEGMENTS);
    else cfg.count = segment_count;
  end

  pwg_front u_front (
    .clk(clk), .rst(rst), .items(items), .q_valid(q_valid), .q_op(q_op), .pop(pop)
  );

  pwg_back u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .q_valid(q_valid), .q_op(q_op), .pop(pop),
    .div_req(div_req), .div_rsp(div_rsp), .res_valid(res_valid), .res_ready(res_ready),
    .res_value(res_value), .res_index(res_index)
  );

  pwg_div u_div (.clk(clk), .rst(rst), .req(div_req), .rsp(div_rsp));

  assign res_ready = !out_valid || results.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_value <= res_value;
      out_index <= res_index;
    end
  end

  assign results.valid         = out_valid;
  assign results.drive_value   = out_value;
  assign results.segment_index = out_index;
endmodule
`default_nettype wire

/* sv/pwg_front.sv */
// Front end: accept items, classify them and queue them for the engine
`default_nettype none
module pwg_front import pwg_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  pwg_in_if.sink    items,
  output logic      q_valid,
  output op_t       q_op,
  input  wire logic pop
);
  op_t        queue [0:1];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  op_t        op_in;

  assign items.ready = (count != 2'd2);
  assign push        = items.valid && items.ready;
  assign q_valid     = (count != 2'd0);
  assign q_op        = queue[rd_ptr];

  always_comb begin
    op_in.is_query = (items.kind == KIND_QUERY);
    op_in.index    = items.entry_index;
    op_in.value    = items.entry_value;
    op_in.duration = items.entry_duration;
    op_in.time_now = items.time_now;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= op_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

/* sv/pwg_div.sv */
// Restoring divider, one quotient bit per cycle
`default_nettype none
module pwg_div import pwg_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  div_req_t  req,
  output div_rsp_t  rsp
);
  logic              busy;
  logic              done;
  logic [6:0]        step;
  logic [DATA_W-1:0] rem;
  logic [PROD_W-1:0] quo;
  logic [DATA_W:0]   shifted;
  logic [DATA_W:0]   trial;
  logic              fits;

  assign shifted = {rem, quo[PROD_W-1]};
  assign trial   = shifted - {1'b0, req.divisor};
  assign fits    = (shifted >= {1'b0, req.divisor});
  assign rsp.done     = done;
  assign rsp.quotient = quo[DATA_W-1:0];

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rem <= '0;
    end else if (busy) begin
      rem <= fits ? trial[DATA_W-1:0] : shifted[DATA_W-1:0];
      quo <= {quo[PROD_W-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 7'd1;
        if (step == 7'(PROD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

/* sv/pwg_back.sv */
// Back end: segment tables, upper-bound scan and interpolation sequencer
`default_nettype none
module pwg_back import pwg_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  cfg_t                      cfg,
  input  wire logic                 q_valid,
  input  op_t                       q_op,
  output logic                      pop,
  output div_req_t                  div_req,
  input  div_rsp_t                  div_rsp,
  output logic                      res_valid,
  input  wire logic                 res_ready,
  output logic signed [DATA_W-1:0]  res_value,
  output logic [SEG_IDX_W-1:0]      res_index
);
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_LD_WR    = 4'd1;
  localparam logic [3:0] S_SCAN     = 4'd2;
  localparam logic [3:0] S_SCAN_END = 4'd3;
  localparam logic [3:0] S_RD0      = 4'd4;
  localparam logic [3:0] S_RD1      = 4'd5;
  localparam logic [3:0] S_RD2      = 4'd6;
  localparam logic [3:0] S_MUL0     = 4'd7;
  localparam logic [3:0] S_MUL1     = 4'd8;
  localparam logic [3:0] S_DIV_GO   = 4'd9;
  localparam logic [3:0] S_DIV      = 4'd10;
  localparam logic [3:0] S_OUT      = 4'd11;

  logic [3:0] state;

  logic [DATA_W-1:0]      st_mem [0:MAX_SEGMENTS];
  logic [MAX_SEGMENTS:0]  st_vld;
  logic [SEG_IDX_W-1:0]   st_raddr;
  logic [DATA_W-1:0]      st_rdata;
  logic                   st_we;
  logic [SEG_IDX_W-1:0]   st_waddr;
  logic [DATA_W-1:0]      st_wdata;

  logic [DATA_W-1:0]      val_mem [0:MAX_SEGMENTS-1];
  logic [ENTRY_IDX_W-1:0] val_raddr;
  logic [DATA_W-1:0]      val_rdata;
  logic                   val_we;

  logic [ENTRY_IDX_W-1:0] ld_index;
  logic [DATA_W-1:0]      ld_dur;
  logic [DATA_W-1:0]      t;
  logic [SEG_IDX_W-1:0]   ptr;
  logic [SEG_IDX_W-1:0]   cmp_idx;
  logic                   cmp_vld;
  logic [SEG_IDX_W-1:0]   idx;
  logic [DATA_W-1:0]      s0;
  logic [DATA_W-1:0]      v0;
  logic [DATA_W-1:0]      a;
  logic [DATA_W-1:0]      d;
  logic [DATA_W:0]        m;
  logic                   neg;
  logic [PROD_W-1:0]      prod;
  logic [DATA_W-1:0]      result;

  logic [SEG_IDX_W-1:0]   idx_inc;
  logic                   has_next;
  logic [ENTRY_IDX_W-1:0] last;
  logic [DATA_W:0]        sum;
  logic [DATA_W:0]        diff;
  logic [DATA_W:0]        mul_op;
  logic [DATA_W+16:0]     mul_out;
  logic                   hit;

  assign idx_inc  = idx + 7'd1;
  assign has_next = (idx_inc < cfg.count);
  assign last     = ENTRY_IDX_W'(cfg.count - 7'd1);
  assign sum      = {1'b0, st_rdata} + {1'b0, ld_dur};
  assign diff     = {val_rdata[DATA_W-1], val_rdata} - {v0[DATA_W-1], v0};
  assign mul_op   = (state == S_MUL0) ? {17'd0, m[15:0]} : {16'd0, m[DATA_W:16]};
  assign mul_out  = a * mul_op[16:0];
  assign hit      = cmp_vld && (st_rdata <= t);

  assign res_valid = (state == S_OUT);
  assign res_value = result;
  assign res_index = idx;

  assign div_req.start    = (state == S_DIV_GO);
  assign div_req.dividend = prod;
  assign div_req.divisor  = d;

  always_comb begin
    pop       = 1'b0;
    st_raddr  = '0;
    val_raddr = '0;
    st_we     = 1'b0;
    st_waddr  = {1'b0, ld_index} + 7'd1;
    st_wdata  = sum[DATA_W] ? '1 : sum[DATA_W-1:0];
    val_we    = 1'b0;
    unique case (state)
      S_IDLE: begin
        pop = q_valid;
        if (q_valid && !q_op.is_query) begin
          st_raddr = {1'b0, q_op.index};
          val_we   = 1'b1;
        end
      end
      S_LD_WR: st_we = 1'b1;
      S_SCAN:  st_raddr = ptr;
      S_RD0: begin
        st_raddr  = idx;
        val_raddr = (idx < cfg.count) ? idx[ENTRY_IDX_W-1:0] : last;
      end
      S_RD1: begin
        st_raddr  = has_next ? idx_inc : idx;
        val_raddr = idx_inc[ENTRY_IDX_W-1:0];
      end
      S_SCAN_END, S_RD2, S_MUL0, S_MUL1, S_DIV_GO, S_DIV, S_OUT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (st_we) st_mem[st_waddr] <= st_wdata;
    st_rdata <= st_vld[st_raddr] ? st_mem[st_raddr] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_vld <= '0;
    end else if (st_we) begin
      st_vld[st_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (val_we) val_mem[q_op.index] <= q_op.value;
    val_rdata <= val_mem[val_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      cmp_vld <= 1'b0;
      idx     <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            ld_index <= q_op.index;
            ld_dur   <= q_op.duration;
            t        <= q_op.time_now;
            ptr      <= 7'd1;
            idx      <= '0;
            cmp_vld  <= 1'b0;
            state    <= q_op.is_query ? S_SCAN : S_LD_WR;
          end
        end
        S_LD_WR: state <= S_IDLE;
        S_SCAN: begin
          if (hit) idx <= cmp_idx;
          cmp_idx <= ptr;
          cmp_vld <= 1'b1;
          ptr     <= ptr + 7'd1;
          if (ptr == cfg.count) state <= S_SCAN_END;
        end
        S_SCAN_END: begin
          if (hit) idx <= cmp_idx;
          cmp_vld <= 1'b0;
          state   <= S_RD0;
        end
        S_RD0: state <= S_RD1;
        S_RD1: begin
          s0 <= st_rdata;
          v0 <= val_rdata;
          if (!cfg.interpolate || !has_next) begin
            result <= val_rdata;
            state  <= S_OUT;
          end else begin
            state <= S_RD2;
          end
        end
        S_RD2: begin
          a     <= t - s0;
          d     <= st_rdata - s0;
          neg   <= diff[DATA_W];
          m     <= diff[DATA_W] ? (~diff + 33'd1) : diff;
          state <= S_MUL0;
        end
        S_MUL0: begin
          prod  <= {16'd0, mul_out};
          state <= S_MUL1;
        end
        S_MUL1: begin
          prod <= prod + {mul_out, 16'd0};
          if (d == '0) begin
            result <= v0;
            state  <= S_OUT;
          end else begin
            state <= S_DIV_GO;
          end
        end
        S_DIV_GO: state <= S_DIV;
        S_DIV: begin
          if (div_rsp.done) begin
            result <= neg ? v0 - div_rsp.quotient : v0 + div_rsp.quotient;
            state  <= S_OUT;
          end
        end
        S_OUT: begin
          if (res_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

/* sv/pwg_checker.sv */
// Port-level checker for the piecewise waveform generator and its binding
`default_nettype none
`include "piecewise_waveform_generator_defines.svh"
module pwg_port_checker import pwg_pkg::*; (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire logic signed [31:0]   out_value,
  input wire logic [SEG_IDX_W-1:0] out_index
);
  `PWG_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid)
  `PWG_ASSERT(a_out_stable, clk, rst, out_valid && !out_ready |=> $stable(out_value) && $stable(out_index))
  `PWG_ASSERT(a_index_range, clk, rst, out_valid |-> out_index <= 7'(MAX_SEGMENTS))
  `PWG_ASSERT_ALWAYS(a_reset_quiet, clk, $past(rst) |-> !out_valid)
endmodule

bind piecewise_waveform_generator pwg_port_checker u_checker (
  .clk(clk), .rst(rst), .out_valid(results.valid), .out_ready(results.ready),
  .out_value(results.drive_value), .out_index(results.segment_index)
);
`default_nettype wire

/* sim/pwg_checker.sv */
// Checker for the piecewise waveform generator: tracks the segment table, predicts and compares
`timescale 1ns / 1ps
module pwg_checker import pwg_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  pwg_in_if                          items,
  pwg_out_if                         results,
  output int                         failures,
  output int                         outstanding
);
  typedef struct packed {
    logic signed [DATA_W-1:0] drive_value;
    logic [SEG_IDX_W-1:0]     segment_index;
  } sample_t;

  logic signed [DATA_W-1:0] seg_value [MAX_SEGMENTS];
  logic [DATA_W-1:0]        seg_start [MAX_SEGMENTS+1];
  logic                     interp_mode;
  logic [SEG_IDX_W-1:0]     count_reg;
  sample_t                  expected_samples[$];

  function automatic sample_t waveform_at(logic [DATA_W-1:0] t);
    sample_t                  s;
    int unsigned              n;
    int unsigned              idx;
    logic signed [DATA_W:0]   diff;
    logic [63:0]              a, d, m, q, r, v0;
    n = count_reg;
    if (n == 0) n = 1;
    if (n > MAX_SEGMENTS) n = MAX_SEGMENTS;
    idx = 0;
    for (int j = 1; j <= n; j++)
      if (seg_start[j] <= t) idx = j;
    if (!interp_mode) begin
      s.drive_value = (idx < n) ? seg_value[idx] : seg_value[n-1];
    end else if (idx + 1 < n) begin
      v0   = {{32{seg_value[idx][31]}}, seg_value[idx]};
      diff = $signed({seg_value[idx+1][31], seg_value[idx+1]}) -
             $signed({seg_value[idx][31], seg_value[idx]});
      a    = {32'd0, t - seg_start[idx]};
      d    = {32'd0, seg_start[idx+1] - seg_start[idx]};
      m    = diff[DATA_W] ? {31'd0, -diff} : {31'd0, diff};
      q    = (d != 0) ? (a * m) / d : 64'd0;
      r    = diff[DATA_W] ? v0 - q : v0 + q;
      s.drive_value = r[31:0];
    end else begin
      s.drive_value = seg_value[n-1];
    end
    s.segment_index = idx[SEG_IDX_W-1:0];
    return s;
  endfunction

  assign outstanding = expected_samples.size();

  always @(posedge clk) begin
    logic [32:0] sum;
    sample_t     got, want;
    int          errs;
    errs = 0;
    if (rst) begin
      for (int i = 0; i < MAX_SEGMENTS; i++) seg_value[i] <= '0;
      for (int i = 0; i <= MAX_SEGMENTS; i++) seg_start[i] <= '0;
      interp_mode <= 1'b0;
      count_reg   <= 7'd1;
      failures    <= 0;
      expected_samples.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_INTERPOLATE) interp_mode <= cfg_data[0];
        else if (cfg_index == CFG_SEGMENT_COUNT) count_reg <= cfg_data;
      end
      if (items.valid && items.ready) begin
        if (items.kind == KIND_LOAD) begin
          seg_value[items.entry_index] <= items.entry_value;
          sum = {1'b0, seg_start[items.entry_index]} + {1'b0, items.entry_duration};
          seg_start[items.entry_index + 1] <= sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        end else begin
          expected_samples.push_back(waveform_at(items.time_now));
        end
      end
      if (results.valid && results.ready) begin
        got.drive_value   = results.drive_value;
        got.segment_index = results.segment_index;
        if (expected_samples.size() == 0) begin
          $error("unexpected result: drive_value %0d segment_index %0d",
                 got.drive_value, got.segment_index);
          errs++;
        end else begin
          want = expected_samples.pop_front();
          if (got.drive_value !== want.drive_value) begin
            $error("drive_value: expected %0d, actual %0d", want.drive_value, got.drive_value);
            errs++;
          end
          if (got.segment_index !== want.segment_index) begin
            $error("segment_index: expected %0d, actual %0d",
                   want.segment_index, got.segment_index);
            errs++;
          end
        end
      end
      if (errs != 0) failures <= failures + errs;
    end
  end
endmodule

/* sim/testbench.sv */
// Testbench top: stimulus, handshake pacing and verdict for the piecewise waveform generator
`timescale 1ns / 1ps
module testbench;
  import pwg_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  calm;
  int                    failures;
  int                    outstanding;

  pwg_in_if  in_ch ();
  pwg_out_if out_ch ();

  piecewise_waveform_generator u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .items(in_ch), .results(out_ch)
  );

  pwg_checker u_checker (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .items(in_ch), .results(out_ch), .failures(failures), .outstanding(outstanding)
  );

  always #5 clk = ~clk;

  initial begin
    #20_000_000;
    $display("piecewise_waveform_generator verification failed");
    $finish;
  end

  always @(posedge clk) begin
    int stall_left;
    if (rst) begin
      stall_left = 0;
      out_ch.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 3);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  task automatic send_item(logic kind, logic [5:0] idx, logic [31:0] val,
                           logic [31:0] dur, logic [31:0] t);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.kind           <= kind;
    in_ch.entry_index    <= idx;
    in_ch.entry_value    <= val;
    in_ch.entry_duration <= dur;
    in_ch.time_now       <= t;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic load_entry(logic [5:0] idx, logic [31:0] val, logic [31:0] dur);
    send_item(KIND_LOAD, idx, val, dur, $urandom);
  endtask

  task automatic query_at(logic [31:0] t);
    send_item(KIND_QUERY, 6'($urandom), $urandom, $urandom, t);
  endtask

  // hold off until the engine has drained
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    wait (outstanding == 0);
    repeat (300) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_duration();
    case ($urandom_range(0, 9))
      0:       return 32'd0;
      1:       return $urandom;
      2:       return 32'hFFFF_FFFF;
      default: return $urandom_range(0, 40);
    endcase
  endfunction

  function automatic logic [31:0] rand_time();
    case ($urandom_range(0, 9))
      0:       return $urandom;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'd0;
      default: return $urandom_range(0, 2000);
    endcase
  endfunction

  initial begin
    int reload_len;
    int phase_items;
    in_ch.valid          <= 1'b0;
    in_ch.kind           <= KIND_LOAD;
    in_ch.entry_index    <= '0;
    in_ch.entry_value    <= '0;
    in_ch.entry_duration <= '0;
    in_ch.time_now       <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_INTERPOLATE;
    cfg_data  <= '0;
    calm      <= 1'b0;
    rst       <= 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // fill the whole table once so no query ever reads an unwritten entry
    for (int i = 0; i < MAX_SEGMENTS; i++) begin
      case (i)
        0:       load_entry(6'(i), 32'h7FFF_FFFF, 32'd0);
        1:       load_entry(6'(i), 32'h8000_0000, 32'd10);
        2:       load_entry(6'(i), 32'h7FFF_FFFF, 32'd1);
        3:       load_entry(6'(i), 32'h0000_0000, 32'd7);
        63:      load_entry(6'(i), $urandom, 32'hFFFF_FFFF);
        default: load_entry(6'(i), $urandom, $urandom_range(1, 30));
      endcase
    end
    query_at(32'd0);
    drain();
    cfg_write(CFG_SEGMENT_COUNT, 7'd64);
    query_at(32'd0);
    query_at(32'd5);
    query_at(32'd10);
    query_at(32'd11);
    query_at(32'hFFFF_FFFF);
    query_at(32'hFFFF_FFFE);
    drain();
    cfg_write(CFG_INTERPOLATE, 7'd1);
    query_at(32'd0);
    query_at(32'd3);
    query_at(32'd10);
    query_at(32'd15);
    query_at(32'hFFFF_FFFF);
    drain();
    cfg_write(CFG_SEGMENT_COUNT, 7'd0);
    query_at(32'd4);
    query_at(32'hFFFF_FFFF);
    drain();
    cfg_write(CFG_SEGMENT_COUNT, 7'd127);
    query_at(32'd20);
    query_at(32'hFFFF_FFFF);
    drain();

    for (int phase = 0; phase < 10; phase++) begin
      if (phase == 9) calm <= 1'b1;
      cfg_write(CFG_INTERPOLATE, 7'($urandom_range(0, 1)));
      case (phase)
        0:       cfg_write(CFG_SEGMENT_COUNT, 7'd1);
        1:       cfg_write(CFG_SEGMENT_COUNT, 7'd64);
        2:       cfg_write(CFG_SEGMENT_COUNT, 7'd2);
        default: cfg_write(CFG_SEGMENT_COUNT, 7'($urandom_range(1, 64)));
      endcase
      phase_items = 0;
      while (phase_items < 200) begin
        case ($urandom_range(0, 9))
          0: begin
            reload_len = $urandom_range(1, 64);
            for (int i = 0; i < reload_len; i++) load_entry(6'(i), $urandom, rand_duration());
            phase_items += reload_len;
          end
          1: begin
            load_entry(6'($urandom), $urandom, rand_duration());
            phase_items++;
          end
          default: begin
            query_at(rand_time());
            phase_items++;
          end
        endcase
        if (phase == 4 && phase_items >= 100 && phase_items < 102) begin
          in_ch.valid <= 1'b0;
          @(posedge clk);
          wait (outstanding == 0);
          @(posedge clk);
        end
      end
      drain();
    end

    if (failures == 0 && outstanding == 0) begin
      $display("piecewise_waveform_generator verification clean");
    end else begin
      $display("piecewise_waveform_generator verification failed");
    end
    $finish;
  end
endmodule
